// ===== hdl/ltb_pkg.sv =====
// ----------------------------------------------------------------------------
// ltb_pkg
// Shared types and constants of the tensor-product Lagrange basis evaluator.
// ----------------------------------------------------------------------------
package ltb_pkg;

  // fixed-point word, signed Q8.24
  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE  = 32'sh0100_0000;
  localparam q_t Q_HALF = 32'sh0080_0000;
  localparam q_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN  = 32'sh8000_0000;

  // support point registers
  localparam int unsigned NUM_SP = 5;
  localparam int unsigned SPW    = 3;
  typedef q_t [NUM_SP-1:0] sp_array_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SP_FIRST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SP_LAST     = 3'd5;

  // input item
  typedef struct packed {
    q_t         coord_x;
    q_t         coord_y;
    q_t         coord_z;
    logic [2:0] subcell;
  } item_t;

  // mapped point passed from front to back
  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } point_t;

  // result item
  typedef struct packed {
    logic [6:0] basis_index;
    q_t         basis_value;
    q_t         grad_x;
    q_t         grad_y;
    q_t         grad_z;
    logic       degenerate;
    logic       final_item;
  } result_t;

endpackage

// ===== hdl/ltb_front.sv =====
// ----------------------------------------------------------------------------
// ltb_front
// Accepts points, drops meaningless subcells and applies the subcell remap.
// ----------------------------------------------------------------------------
module ltb_front #(
  parameter int unsigned DIM = 2
) (
  input  logic            start_i,
  input  logic            full_i,
  input  ltb_pkg::item_t  item_i,
  output logic            push_o,
  output ltb_pkg::point_t pt_o
);

  logic sub_ok;
  logic hi_x;
  logic hi_y;

  // subcell classification
  always_comb begin
    sub_ok = (item_i.subcell == 3'd0);
    if (DIM == 1) sub_ok = sub_ok || (item_i.subcell <= 3'd2);
    if (DIM == 2) sub_ok = sub_ok || (item_i.subcell <= 3'd4);
    hi_x = (DIM == 1) ? (item_i.subcell == 3'd2)
                      : ((item_i.subcell == 3'd2) || (item_i.subcell == 3'd4));
    hi_y = (item_i.subcell >= 3'd3);
  end

  assign push_o = start_i && !full_i && sub_ok;

  // coordinate remap to half cells
  always_comb begin
    pt_o.x = item_i.coord_x;
    pt_o.y = item_i.coord_y;
    pt_o.z = item_i.coord_z;
    if (item_i.subcell != 3'd0) begin
      pt_o.x = (item_i.coord_x >>> 1) + (hi_x ? ltb_pkg::Q_HALF : 32'sd0);
      if (DIM >= 2) begin
        pt_o.y = (item_i.coord_y >>> 1) + (hi_y ? ltb_pkg::Q_HALF : 32'sd0);
      end
    end
  end

endmodule

// ===== hdl/ltb_queue.sv =====
// ----------------------------------------------------------------------------
// ltb_queue
// Two-entry point queue between front and back.
// ----------------------------------------------------------------------------
module ltb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ltb_pkg::point_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output ltb_pkg::point_t head_o
);

  ltb_pkg::point_t mem_q [2];
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  // pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/ltb_div.sv =====
// ----------------------------------------------------------------------------
// ltb_div
// Radix-2 restoring divider: (num * 2^24) / den toward zero, saturated.
// ----------------------------------------------------------------------------
module ltb_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ltb_pkg::q_t   num_i,
  input  ltb_pkg::q_t   den_i,
  output logic          done_o,
  output ltb_pkg::q_t   quot_o
);

  localparam int unsigned SHW = 56;

  logic             run_q;
  logic             done_q;
  logic [5:0]       cnt_q;
  logic [31:0]      rem_q;
  logic [31:0]      dvs_q;
  logic [SHW-1:0]   sh_q;
  logic             neg_q;
  ltb_pkg::q_t      quot_q;

  logic [31:0]      num_mag;
  logic [31:0]      den_mag;
  logic [32:0]      rs;
  logic             ge;
  logic [31:0]      rem_n;
  logic [SHW-1:0]   sh_n;
  ltb_pkg::q_t      quot_n;

  // operand magnitudes
  assign num_mag = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign den_mag = den_i[31] ? (~den_i + 32'd1) : den_i;

  // one quotient bit per cycle
  always_comb begin
    rs    = {rem_q, sh_q[SHW-1]};
    ge    = (rs >= {1'b0, dvs_q});
    rem_n = ge ? 32'(rs - {1'b0, dvs_q}) : rs[31:0];
    sh_n  = {sh_q[SHW-2:0], ge};
    if (!neg_q) begin
      quot_n = (sh_n > SHW'(ltb_pkg::Q_MAX)) ? ltb_pkg::Q_MAX : 32'(sh_n);
    end else begin
      quot_n = (sh_n > SHW'(33'h0_8000_0000)) ? ltb_pkg::Q_MIN : 32'(~sh_n + SHW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == 32'sd0) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= 6'd0;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(SHW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= 32'd0;
      dvs_q  <= den_mag;
      sh_q   <= {num_mag, 24'd0};
      neg_q  <= num_i[31] ^ den_i[31];
      quot_q <= num_i[31] ? ltb_pkg::Q_MIN : ltb_pkg::Q_MAX;
    end else if (run_q) begin
      rem_q <= rem_n;
      sh_q  <= sh_n;
      if (cnt_q == 6'(SHW - 1)) begin
        quot_q <= quot_n;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/ltb_back.sv =====
// ----------------------------------------------------------------------------
// ltb_back
// Sequencer: builds the 1D factor tables with one shared multiplier and the
// divider, then forms and emits every tensor-product basis function.
// ----------------------------------------------------------------------------
module ltb_back #(
  parameter int unsigned DIM        = 2,
  parameter int unsigned MAX_POINTS = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  ltb_pkg::point_t      head_i,
  input  logic [2:0]           point_count_i,
  input  ltb_pkg::sp_array_t   sp_i,
  output logic                 pop_o,
  output logic                 strobe_o,
  output ltb_pkg::result_t     result_o
);

  localparam int unsigned DW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned EW    = $clog2(DIM + 1);
  localparam int unsigned PW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW    = $clog2(MAX_POINTS);
  localparam int unsigned DEPTH = DIM * MAX_POINTS;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_PI       = 9'b000000010,
    ST_FETCH    = 9'b000000100,
    ST_MUL      = 9'b000001000,
    ST_DIV_GO   = 9'b000010000,
    ST_DIV_WAIT = 9'b000100000,
    ST_EFETCH   = 9'b001000000,
    ST_EMUL     = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    PASS_NUM = 2'd0,
    PASS_DEN = 2'd1,
    PASS_DER = 2'd2
  } pass_e;

  function automatic ltb_pkg::q_t sat33(input logic signed [32:0] v);
    ltb_pkg::q_t r;
    if (v > 33'sh0_7FFF_FFFF) r = ltb_pkg::Q_MAX;
    else if (v < -33'sh0_8000_0000) r = ltb_pkg::Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic ltb_pkg::q_t qmul(input ltb_pkg::q_t a, input ltb_pkg::q_t b);
    logic signed [63:0] p;
    logic signed [39:0] s;
    ltb_pkg::q_t        r;
    p = a * b;
    s = p[63:24];
    if (s > 40'sh00_7FFF_FFFF) r = ltb_pkg::Q_MAX;
    else if (s < -40'sh00_8000_0000) r = ltb_pkg::Q_MIN;
    else r = s[31:0];
    return r;
  endfunction

  state_e            state_q, state_d;
  pass_e             pass_q, pass_d;
  logic [PW-1:0]     n_q, n_d;
  logic [DW-1:0]     d_q, d_d;
  logic [IW-1:0]     i_q, i_d;
  logic [PW-1:0]     j_q, j_d;
  logic [PW-1:0]     m_q, m_d;
  logic              zero_q, zero_d;
  logic              dsel_q, dsel_d;
  logic [6:0]        k_q, k_d;
  logic [IW-1:0]     idx_q [DIM];
  logic [IW-1:0]     idx_d [DIM];
  logic [EW-1:0]     c_q, c_d;
  logic [EW-1:0]     e_q, e_d;
  ltb_pkg::q_t       acc_q, acc_d;
  ltb_pkg::q_t       opnd_q, opnd_d;
  ltb_pkg::q_t       pi_q, pi_d;
  ltb_pkg::q_t       num_q, num_d;
  ltb_pkg::q_t       den_q, den_d;
  ltb_pkg::q_t       dsum_q, dsum_d;
  ltb_pkg::q_t       value_q, value_d;
  ltb_pkg::q_t       grad_q [DIM];
  ltb_pkg::q_t       grad_d [DIM];

  ltb_pkg::q_t       val_mem [DEPTH];
  ltb_pkg::q_t       der_mem [DEPTH];
  ltb_pkg::q_t       eop_q;

  logic [ltb_pkg::SPW-1:0] sp_addr;
  ltb_pkg::q_t       sp_rd;
  ltb_pkg::q_t       coord;
  ltb_pkg::q_t       diff_a;
  ltb_pkg::q_t       opnd_new;
  ltb_pkg::q_t       mul;
  logic              skip;
  logic [PW-1:0]     m_next;
  logic              last_idx;
  logic              carry;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              use_der;
  logic              rd_en;
  logic              val_we;
  logic              der_we;
  logic              div_start;
  ltb_pkg::q_t       div_num;
  logic              div_done;
  ltb_pkg::q_t       div_quot;
  ltb_pkg::q_t       gpad [3];

  // shared divider
  ltb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // operand selection and shared multiplier
  always_comb begin
    sp_addr  = (state_q == ST_PI) ? ltb_pkg::SPW'(i_q) : ltb_pkg::SPW'(j_q);
    sp_rd    = sp_i[sp_addr];
    coord    = (d_q == DW'(0)) ? head_i.x : ((d_q == DW'(1)) ? head_i.y : head_i.z);
    diff_a   = (pass_q == PASS_DEN) ? pi_q : coord;
    opnd_new = sat33({diff_a[31], diff_a} - {sp_rd[31], sp_rd});
    skip     = (j_q == PW'(i_q)) || ((pass_q == PASS_DER) && (j_q == m_q));
    mul      = qmul(acc_q, (state_q == ST_EMUL) ? eop_q : opnd_q);
    m_next   = m_q + PW'(1);
    if (m_next == PW'(i_q)) m_next = m_next + PW'(1);
    wr_addr  = AW'(d_q) * AW'(MAX_POINTS) + AW'(i_q);
    rd_addr  = AW'(e_q) * AW'(MAX_POINTS) + AW'(idx_q[e_q[DW-1:0]]);
    use_der  = (c_q != EW'(0)) && (e_q == c_q - EW'(1));
    last_idx = 1'b1;
    for (int unsigned g = 0; g < DIM; g++) begin
      if (PW'(idx_q[g]) != n_q - PW'(1)) last_idx = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    n_d     = n_q;
    d_d     = d_q;
    i_d     = i_q;
    j_d     = j_q;
    m_d     = m_q;
    zero_d  = zero_q;
    dsel_d  = dsel_q;
    k_d     = k_q;
    idx_d   = idx_q;
    c_d     = c_q;
    e_d     = e_q;
    acc_d   = acc_q;
    opnd_d  = opnd_q;
    pi_d    = pi_q;
    num_d   = num_q;
    den_d   = den_q;
    dsum_d  = dsum_q;
    value_d = value_q;
    grad_d  = grad_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    val_we    = 1'b0;
    der_we    = 1'b0;
    div_start = 1'b0;
    div_num   = dsel_q ? dsum_q : num_q;
    carry     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (point_count_i < 3'd2) n_d = PW'(2);
          else if (point_count_i > 3'(MAX_POINTS)) n_d = PW'(MAX_POINTS);
          else n_d = PW'(point_count_i);
          d_d     = '0;
          i_d     = '0;
          zero_d  = 1'b0;
          state_d = ST_PI;
        end
      end
      ST_PI: begin
        pi_d    = sp_rd;
        pass_d  = PASS_NUM;
        j_d     = '0;
        acc_d   = ltb_pkg::Q_ONE;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (j_q == n_q) begin
          j_d   = '0;
          acc_d = ltb_pkg::Q_ONE;
          case (pass_q)
            PASS_NUM: begin
              num_d  = acc_q;
              pass_d = PASS_DEN;
            end
            PASS_DEN: begin
              den_d  = acc_q;
              if (acc_q == 32'sd0) zero_d = 1'b1;
              pass_d = PASS_DER;
              dsum_d = '0;
              m_d    = (i_q == IW'(0)) ? PW'(1) : PW'(0);
            end
            default: begin
              dsum_d = sat33({dsum_q[31], dsum_q} + {acc_q[31], acc_q});
              if (m_next >= n_q) begin
                dsel_d  = 1'b0;
                state_d = ST_DIV_GO;
              end else begin
                m_d = m_next;
              end
            end
          endcase
        end else if (skip) begin
          j_d = j_q + PW'(1);
        end else begin
          opnd_d  = opnd_new;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d   = mul;
        j_d     = j_q + PW'(1);
        state_d = ST_FETCH;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (!dsel_q) begin
            val_we  = 1'b1;
            dsel_d  = 1'b1;
            state_d = ST_DIV_GO;
          end else begin
            der_we = 1'b1;
            dsel_d = 1'b0;
            if (PW'(i_q) == n_q - PW'(1)) begin
              i_d = '0;
              if (d_q == DW'(DIM - 1)) begin
                k_d = '0;
                for (int unsigned g = 0; g < DIM; g++) idx_d[g] = '0;
                c_d     = '0;
                e_d     = '0;
                acc_d   = ltb_pkg::Q_ONE;
                state_d = ST_EFETCH;
              end else begin
                d_d     = d_q + DW'(1);
                state_d = ST_PI;
              end
            end else begin
              i_d     = i_q + IW'(1);
              state_d = ST_PI;
            end
          end
        end
      end
      ST_EFETCH: begin
        if (e_q == EW'(DIM)) begin
          if (c_q == EW'(0)) value_d = acc_q;
          for (int unsigned g = 0; g < DIM; g++) begin
            if (c_q == EW'(g + 1)) grad_d[g] = acc_q;
          end
          if (c_q == EW'(DIM)) begin
            state_d = ST_OUT;
          end else begin
            c_d   = c_q + EW'(1);
            e_d   = '0;
            acc_d = ltb_pkg::Q_ONE;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = ST_EMUL;
        end
      end
      ST_EMUL: begin
        acc_d   = mul;
        e_d     = e_q + EW'(1);
        state_d = ST_EFETCH;
      end
      ST_OUT: begin
        if (last_idx) begin
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 7'd1;
          for (int unsigned g = 0; g < DIM; g++) begin
            if (carry) begin
              if (PW'(idx_q[g]) == n_q - PW'(1)) begin
                idx_d[g] = '0;
              end else begin
                idx_d[g] = idx_q[g] + IW'(1);
                carry    = 1'b0;
              end
            end
          end
          c_d     = '0;
          e_d     = '0;
          acc_d   = ltb_pkg::Q_ONE;
          state_d = ST_EFETCH;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_NUM;
      n_q     <= PW'(2);
      d_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      zero_q  <= 1'b0;
      dsel_q  <= 1'b0;
      k_q     <= '0;
      c_q     <= '0;
      e_q     <= '0;
      for (int unsigned g = 0; g < DIM; g++) idx_q[g] <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      n_q     <= n_d;
      d_q     <= d_d;
      i_q     <= i_d;
      j_q     <= j_d;
      m_q     <= m_d;
      zero_q  <= zero_d;
      dsel_q  <= dsel_d;
      k_q     <= k_d;
      c_q     <= c_d;
      e_q     <= e_d;
      idx_q   <= idx_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    opnd_q  <= opnd_d;
    pi_q    <= pi_d;
    num_q   <= num_d;
    den_q   <= den_d;
    dsum_q  <= dsum_d;
    value_q <= value_d;
    grad_q  <= grad_d;
  end

  // 1D factor tables, registered read
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[wr_addr] <= div_quot;
    if (der_we) der_mem[wr_addr] <= div_quot;
    if (rd_en) eop_q <= use_der ? der_mem[rd_addr] : val_mem[rd_addr];
  end

  // result assembly
  always_comb begin
    gpad[0] = '0;
    gpad[1] = '0;
    gpad[2] = '0;
    for (int unsigned g = 0; g < DIM; g++) gpad[g] = grad_q[g];
    result_o.basis_index = k_q;
    result_o.basis_value = value_q;
    result_o.grad_x      = gpad[0];
    result_o.grad_y      = gpad[1];
    result_o.grad_z      = gpad[2];
    result_o.degenerate  = zero_q;
    result_o.final_item  = last_idx;
  end

  assign strobe_o = (state_q == ST_OUT);

endmodule

// ===== hdl/lagrange_tensor_basis_eval.sv =====
// ----------------------------------------------------------------------------
// lagrange_tensor_basis_eval
// Tensor-product Lagrange basis values and gradients in Q8.24 at one point.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  point    | start / busy                | item_i   (ltb_pkg::item_t)
//  result   | result_strobe_o, one cycle  | result_o (ltb_pkg::result_t)
//  config   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
//  A point first builds the DIM*n entries of the 1D tables (the shared
//  multiplier and the one-bit-per-cycle divider, a zero denominator
//  ending a quotient early), then forms and sends its n^DIM results.
//  A two-entry queue holds further points, busy is high while it is full.
//  Results leave at one per strobe and cannot be held off.
//  Reset gives n = 5 and support points 0, 0.25, 0.5, 0.75, 1.0.
// ----------------------------------------------------------------------------
module lagrange_tensor_basis_eval #(
  parameter int unsigned DIM        = 2,
  parameter int unsigned MAX_POINTS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  ltb_pkg::item_t                    item_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ltb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  output logic                              result_strobe_o,
  output ltb_pkg::result_t                  result_o
);

  logic               [2:0] pc_q;
  ltb_pkg::sp_array_t       sp_q;
  logic                     push;
  ltb_pkg::point_t          push_pt;
  logic                     full;
  logic                     q_valid;
  ltb_pkg::point_t          q_head;
  logic                     pop;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= 3'd5;
      sp_q[0] <= 32'sh0000_0000;
      sp_q[1] <= 32'sh0040_0000;
      sp_q[2] <= 32'sh0080_0000;
      sp_q[3] <= 32'sh00C0_0000;
      sp_q[4] <= 32'sh0100_0000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        ltb_pkg::REG_POINT_COUNT: pc_q <= cfg_data_i[2:0];
        [ltb_pkg::REG_SP_FIRST:ltb_pkg::REG_SP_LAST]:
          sp_q[ltb_pkg::SPW'(cfg_index_i - ltb_pkg::REG_SP_FIRST)] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ltb_front #(.DIM(DIM)) u_front (
    .start_i (start),
    .full_i  (full),
    .item_i  (item_i),
    .push_o  (push),
    .pt_o    (push_pt)
  );

  ltb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_pt),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  ltb_back #(.DIM(DIM), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .head_i        (q_head),
    .point_count_i (pc_q),
    .sp_i          (sp_q),
    .pop_o         (pop),
    .strobe_o      (result_strobe_o),
    .result_o      (result_o)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tensor-product Lagrange basis evaluator. A
// fixed-point predictor builds every basis value and gradient for each
// transferred point. A scoreboard checks each strobed result in order,
// over several support point settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM        = 2;
  localparam int unsigned MAX_POINTS = 5;
  localparam int unsigned DRAIN_CYC  = 3000;
  localparam int unsigned WDOG_LIMIT = 40000;

  typedef logic [ltb_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_UNUSED_A = 3'd6;
  localparam cfg_idx_t REG_UNUSED_B = 3'd7;

  // predicted basis results, oldest first
  class basis_scoreboard;
    int unsigned       count_reg;
    longint            sp [ltb_pkg::NUM_SP];
    ltb_pkg::result_t  basis_q [$];
    int                errors;
    longint            val [3][MAX_POINTS];
    longint            der [3][MAX_POINTS];
    bit                zero_den;

    function new();
      count_reg = 5;
      sp[0] = 0; sp[1] = 4194304; sp[2] = 8388608; sp[3] = 12582912;
      sp[4] = 16777216;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] data);
      if (idx == ltb_pkg::REG_POINT_COUNT) count_reg = {29'd0, data[2:0]};
      else if (idx >= ltb_pkg::REG_SP_FIRST && idx <= ltb_pkg::REG_SP_LAST)
        sp[idx - ltb_pkg::REG_SP_FIRST] = longint'($signed(data));
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      return sat((a * b) >>> 24);
    endfunction

    function longint qdiv(longint num, longint den);
      if (den == 0) begin
        zero_den = 1'b1;
        return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      return sat((num * 64'sd16777216) / den);
    endfunction

    // 1d factor values and derivatives for one coordinate
    function void factors_1d(int d, longint x, int n);
      longint num, den, dsum, prod;
      for (int i = 0; i < n; i++) begin
        num = 64'sd16777216; den = 64'sd16777216; dsum = 0;
        for (int j = 0; j < n; j++)
          if (j != i) begin
            num = qmul(num, sat(x - sp[j]));
            den = qmul(den, sat(sp[i] - sp[j]));
          end
        for (int m = 0; m < n; m++)
          if (m != i) begin
            prod = 64'sd16777216;
            for (int j = 0; j < n; j++)
              if (j != i && j != m) prod = qmul(prod, sat(x - sp[j]));
            dsum = sat(dsum + prod);
          end
        val[d][i] = qdiv(num, den);
        der[d][i] = qdiv(dsum, den);
      end
    endfunction

    function void note_point(ltb_pkg::item_t it);
      int unsigned n, total, rest;
      int unsigned idx [3];
      longint coord [3];
      longint v, acc;
      longint g [3];
      bit hi [2];
      ltb_pkg::result_t r;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      coord[0] = longint'(it.coord_x);
      coord[1] = longint'(it.coord_y);
      coord[2] = longint'(it.coord_z);
      zero_den = 1'b0;
      // subcell remap, meaningless selectors give nothing
      if (it.subcell != 0) begin
        if (DIM == 1 && it.subcell <= 2) begin
          hi[0] = (it.subcell == 2); hi[1] = 1'b0;
        end else if (DIM == 2 && it.subcell <= 4) begin
          hi[0] = (it.subcell == 2 || it.subcell == 4); hi[1] = (it.subcell >= 3);
        end else begin
          return;
        end
        for (int d = 0; d < DIM && d < 2; d++)
          coord[d] = (coord[d] >>> 1) + (hi[d] ? 64'sd8388608 : 64'sd0);
      end
      for (int d = 0; d < DIM; d++) factors_1d(d, coord[d], n);
      total = 1;
      for (int d = 0; d < DIM; d++) total *= n;
      for (int unsigned k = 0; k < total; k++) begin
        rest = k;
        idx[0] = 0; idx[1] = 0; idx[2] = 0;
        g[0] = 0; g[1] = 0; g[2] = 0;
        for (int d = 0; d < DIM; d++) begin
          idx[d] = rest % n; rest /= n;
        end
        v = 64'sd16777216;
        for (int d = 0; d < DIM; d++) v = qmul(v, val[d][idx[d]]);
        for (int c = 0; c < DIM; c++) begin
          acc = 64'sd16777216;
          for (int d = 0; d < DIM; d++)
            acc = qmul(acc, (d == c) ? der[d][idx[d]] : val[d][idx[d]]);
          g[c] = acc;
        end
        r.basis_index = k[6:0];
        r.basis_value = v[31:0];
        r.grad_x      = g[0][31:0];
        r.grad_y      = g[1][31:0];
        r.grad_z      = g[2][31:0];
        r.degenerate  = zero_den;
        r.final_item  = (k + 1 == total);
        basis_q.insert(basis_q.size(), r);
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(ltb_pkg::result_t got);
      ltb_pkg::result_t want;
      if (basis_q.size() == 0) begin
        report("unexpected result", longint'(got.basis_index), 0);
        return;
      end
      want = basis_q.pop_front();
      if (got.basis_index != want.basis_index)
        report("basis_index", got.basis_index, want.basis_index);
      if (got.basis_value != want.basis_value)
        report("basis_value", got.basis_value, want.basis_value);
      if (got.grad_x != want.grad_x) report("grad_x", got.grad_x, want.grad_x);
      if (got.grad_y != want.grad_y) report("grad_y", got.grad_y, want.grad_y);
      if (got.grad_z != want.grad_z) report("grad_z", got.grad_z, want.grad_z);
      if (got.degenerate != want.degenerate)
        report("degenerate", got.degenerate, want.degenerate);
      if (got.final_item != want.final_item)
        report("final_item", got.final_item, want.final_item);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  ltb_pkg::item_t       item_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  cfg_idx_t             cfg_index_i;
  logic [31:0]          cfg_data_i;
  logic                 result_strobe_o;
  ltb_pkg::result_t     result_o;

  basis_scoreboard sb;
  int unsigned     idle_cycles;
  bit              gaps_on;

  lagrange_tensor_basis_eval #(.DIM(DIM), .MAX_POINTS(MAX_POINTS)) dut (.*);

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o) sb.check(result_o);
      if (result_strobe_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAIL lagrange_tensor_basis_eval");
        $finish;
      end
    end
  end

  // register write transfer
  task write_reg(cfg_idx_t idx, logic [31:0] data);
    if (gaps_on && $urandom_range(0, 99) < 31) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // point transfer, start stays high across back-to-back items
  task send_point(ltb_pkg::item_t it);
    if (gaps_on && $urandom_range(0, 99) < 31) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
    sb.note_point(it);
    @(negedge clk_i);
  endtask

  // wait until the block has drained
  task settle();
    start = 1'b0;
    while (sb.basis_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function ltb_pkg::item_t rand_point();
    ltb_pkg::item_t it;
    it.coord_x = ($urandom_range(0, 3) == 0) ? $urandom
                                             : 32'($urandom_range(0, 64 << 20)) - (24 << 20);
    it.coord_y = ($urandom_range(0, 3) == 0) ? $urandom
                                             : 32'($urandom_range(0, 64 << 20)) - (24 << 20);
    it.coord_z = $urandom;
    it.subcell = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4))
                                            : 3'($urandom_range(5, 7));
    return it;
  endfunction

  task random_points(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      gaps_on = !(i >= count / 3 && i < count / 2);
      send_point(rand_point());
    end
    gaps_on = 1'b1;
  endtask

  // support points near an even spread with jitter
  task spread_support(int unsigned n);
    for (int unsigned i = 0; i < ltb_pkg::NUM_SP; i++)
      write_reg(cfg_idx_t'(ltb_pkg::REG_SP_FIRST + i),
                32'(i * (16777216 / (n - 1))) + 32'($urandom_range(0, 1 << 20)) - (1 << 19));
  endtask

  initial begin
    ltb_pkg::item_t it;
    ltb_pkg::q_t    corners [4];
    sb = new();
    idle_cycles = 0;
    gaps_on     = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes and every subcell selector
    corners[0] = ltb_pkg::Q_MAX; corners[1] = ltb_pkg::Q_MIN;
    corners[2] = '0; corners[3] = ltb_pkg::Q_ONE;
    for (int i = 0; i < 8; i++) begin
      it.coord_x = corners[i % 4];
      it.coord_y = corners[(i + 1) % 4];
      it.coord_z = corners[(i + 2) % 4];
      it.subcell = 3'(i);
      send_point(it);
    end
    for (int i = 0; i < 8; i++) begin
      it.coord_x = ltb_pkg::Q_HALF + 32'(i << 21);
      it.coord_y = -32'(i << 20);
      it.coord_z = ~32'd0;
      it.subcell = 3'(i % 5);
      send_point(it);
    end
    random_points(40);

    // two points at the range extremes
    settle();
    write_reg(ltb_pkg::REG_POINT_COUNT, 32'd2);
    write_reg(ltb_pkg::REG_SP_FIRST, ltb_pkg::Q_MIN);
    write_reg(cfg_idx_t'(ltb_pkg::REG_SP_FIRST + 3'd1), ltb_pkg::Q_MAX);
    random_points(20);

    // count below range with coinciding points, unused indexes
    settle();
    write_reg(ltb_pkg::REG_POINT_COUNT, 32'd1);
    write_reg(ltb_pkg::REG_SP_FIRST, '0);
    write_reg(cfg_idx_t'(ltb_pkg::REG_SP_FIRST + 3'd1), '0);
    write_reg(REG_UNUSED_A, $urandom);
    write_reg(REG_UNUSED_B, $urandom);
    random_points(10);

    // three points, jittered spread
    settle();
    write_reg(ltb_pkg::REG_POINT_COUNT, 32'd3);
    spread_support(3);
    random_points(50);

    // count above range acts as the maximum
    settle();
    write_reg(ltb_pkg::REG_POINT_COUNT, 32'd7);
    spread_support(5);
    random_points(40);

    // four points, fully random words
    settle();
    write_reg(ltb_pkg::REG_POINT_COUNT, 32'd4);
    for (int unsigned i = 0; i < ltb_pkg::NUM_SP; i++)
      write_reg(cfg_idx_t'(ltb_pkg::REG_SP_FIRST + i), $urandom);
    random_points(30);

    // zero count acts as two, last support register at the top extreme
    settle();
    write_reg(ltb_pkg::REG_POINT_COUNT, 32'd0);
    spread_support(2);
    write_reg(ltb_pkg::REG_SP_LAST, ltb_pkg::Q_MAX);
    random_points(15);

    start = 1'b0;
    while (sb.basis_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0 && sb.basis_q.size() == 0)
      $display("PASS lagrange_tensor_basis_eval");
    else
      $display("FAIL lagrange_tensor_basis_eval");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ltb_pkg.sv
hdl/ltb_front.sv
hdl/ltb_queue.sv
hdl/ltb_div.sv
hdl/ltb_back.sv
hdl/lagrange_tensor_basis_eval.sv
sim/testbench.sv
